/* rtl/aabb_frustum_cull_assert.svh */
// Assertion macros used by the culling block's top-level RTL.
// Each macro takes a label, the clock, the active-low reset, an antecedent and a consequent.
`ifndef AABB_FRUSTUM_CULL_ASSERT_SVH
`define AABB_FRUSTUM_CULL_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication.
`define AFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define AFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define AFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define AFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/afc_pkg.sv */
`timescale 1ns / 1ps

package afc_pkg;

  // Number format and problem size.
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int NUM_PLANES  = 6;
  localparam int NUM_TERMS   = 4;
  localparam int NUM_ROWS    = 4;
  localparam int NUM_AXES    = 3;
  localparam int FIELD_W     = 32;

  // Datapath widths: plane coefficients carry one extra bit, the accumulator two more.
  localparam int COEF_W = COORD_WIDTH + 1;
  localparam int PROD_W = COEF_W + COORD_WIDTH;
  localparam int ACC_W  = PROD_W + 2;

  // Counter and index widths.
  localparam int PLANE_W = $clog2(NUM_PLANES);
  localparam int TERM_W  = $clog2(NUM_TERMS);
  localparam int ROW_W   = $clog2(NUM_ROWS);

  // Stream widths.
  localparam int IN_DATA_W  = (NUM_TERMS + 2 * NUM_AXES) * FIELD_W;
  localparam int IN_USER_W  = 1 + ROW_W;
  localparam int OUT_DATA_W = 8;

  // Function codes.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TEST = 1'b1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // Control for one term issued to the multiply-accumulate unit.
  typedef struct packed {
    logic issue;
    logic minus;
    logic first;
    logic last;
    logic wterm;
  } afc_ctl_t;

  // Operands for one issued term.
  typedef struct packed {
    coord_t r3;
    coord_t rk;
    coord_t mn;
    coord_t mx;
  } afc_opd_t;

  // Per-plane status from the unit.
  typedef struct packed {
    logic done;
    logic neg;
  } afc_stat_t;

endpackage

/* rtl/afc_dot.sv */
`timescale 1ns / 1ps

// Shared plane evaluator: forms one plane coefficient, multiplies it by the chosen
// box coordinate (or aligns w) and accumulates, one term per cycle in three stages.
module afc_dot import afc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  afc_ctl_t  ctl,
  input  afc_opd_t  opd,
  output afc_stat_t stat
);

  afc_ctl_t                   s1_ctl_r;
  afc_ctl_t                   s2_ctl_r;
  logic signed [COEF_W-1:0]   coef_r;
  logic signed [COEF_W-1:0]   coef_nxt;
  coord_t                     mn_r;
  coord_t                     mx_r;
  logic signed [COEF_W-1:0]   r3_x;
  logic signed [COEF_W-1:0]   rk_x;
  coord_t                     pt_sel;
  logic signed [PROD_W-1:0]   mul_w;
  logic signed [PROD_W-1:0]   w_w;
  logic signed [PROD_W-1:0]   prod_nxt;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    prod_x;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [ACC_W-1:0]    acc_sum;
  afc_stat_t                  stat_r;

  // Stage 1: plane coefficient is row 3 plus or minus the axis row.
  assign r3_x     = {opd.r3[COORD_WIDTH-1], opd.r3};
  assign rk_x     = {opd.rk[COORD_WIDTH-1], opd.rk};
  assign coef_nxt = ctl.minus ? (r3_x - rk_x) : (r3_x + rk_x);

  // Stage 2: pick the corner furthest along the normal and multiply.
  assign pt_sel   = coef_r[COEF_W-1] ? mn_r : mx_r;
  assign mul_w    = coef_r * pt_sel;
  assign w_w      = $signed({{(PROD_W-COEF_W){coef_r[COEF_W-1]}}, coef_r}) <<< FRAC_BITS;
  assign prod_nxt = s1_ctl_r.wterm ? w_w : mul_w;

  // Stage 3: accumulate, restarting at the first term of each plane.
  assign prod_x  = $signed({{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r});
  assign acc_sum = (s2_ctl_r.first ? '0 : acc_r) + prod_x;

  // Stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
      stat_r   <= '0;
    end else begin
      s1_ctl_r    <= ctl;
      s2_ctl_r    <= s1_ctl_r;
      stat_r.done <= s2_ctl_r.issue && s2_ctl_r.last;
      stat_r.neg  <= acc_sum[ACC_W-1];
    end
  end

  // Stage data.
  always_ff @(posedge clk) begin
    coef_r <= coef_nxt;
    mn_r   <= opd.mn;
    mx_r   <= opd.mx;
    prod_r <= prod_nxt;
    if (s2_ctl_r.issue) begin
      acc_r <= acc_sum;
    end
  end

  assign stat = stat_r;

endmodule

/* rtl/aabb_frustum_cull.sv */
`timescale 1ns / 1ps

// View-frustum culling of axis-aligned boxes. A beat with tuser func 0 loads one row of the
// view-projection matrix; it produces no output beat. A beat with func 1 tests a box
// against the six planes row3 +/- rows 0..2 using the corner furthest along each normal,
// and returns one output beat whose bit 0 is 1 if the box is visible. After a test beat
// the input stays closed until the result is in the output register. One shared
// multiply-accumulate unit takes one term per cycle (three products and the w term, four
// per plane, 24 in all). Its pipeline then drains and the hold state loads the output
// register, after which the input reopens. That last step waits while an earlier output
// beat is still held by out_tready, which lengthens the closed time. The matrix is all
// zero after reset, so a test before any load reports visible. Values are signed Q16.16
// and all sums are kept at full width.
`include "aabb_frustum_cull_assert.svh"

module aabb_frustum_cull import afc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // coef_0, coef_1, coef_2, coef_3, min_x, min_y, min_z, max_x, max_y, max_z
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // func, row_index
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // visible, then zero padding
  output logic [OUT_DATA_W-1:0] out_tdata
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_HOLD} state_t;

  state_t             state_r;
  logic               issuing_r;
  logic [PLANE_W-1:0] plane_r;
  logic [TERM_W-1:0]  term_r;
  logic [PLANE_W-1:0] done_cnt_r;
  logic               visible_r;
  logic               out_tvalid_r;
  logic               out_vis_r;

  coord_t             row_r   [NUM_ROWS][NUM_TERMS];
  coord_t             box_mn_r[NUM_TERMS];
  coord_t             box_mx_r[NUM_TERMS];

  logic               in_fire;
  logic               in_func;
  logic [ROW_W-1:0]   in_row;
  logic [ROW_W-1:0]   axis;
  afc_ctl_t           ctl;
  afc_opd_t           opd;
  afc_stat_t          stat;

  assign in_fire   = in_tvalid && in_tready;
  assign in_func   = in_tuser[0];
  assign in_row    = in_tuser[IN_USER_W-1:1];
  assign in_tready = (state_r == S_IDLE);

  // Matrix rows: cleared by reset, written by load beats.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int c = 0; c < NUM_TERMS; c++) begin
          row_r[r][c] <= '0;
        end
      end
    end else if (in_fire && in_func == FUNC_LOAD) begin
      for (int c = 0; c < NUM_TERMS; c++) begin
        row_r[in_row][c] <= in_tdata[c*FIELD_W +: COORD_WIDTH];
      end
    end
  end

  // Box corners are captured on a test beat; the w slot reads as zero.
  always_ff @(posedge clk) begin
    if (in_fire && in_func == FUNC_TEST) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        box_mn_r[k] <= in_tdata[(NUM_TERMS + k)*FIELD_W +: COORD_WIDTH];
        box_mx_r[k] <= in_tdata[(NUM_TERMS + NUM_AXES + k)*FIELD_W +: COORD_WIDTH];
      end
      box_mn_r[NUM_TERMS-1] <= '0;
      box_mx_r[NUM_TERMS-1] <= '0;
    end
  end

  // Term issue: planes pair up as plus and minus of the same axis row.
  assign axis      = ROW_W'(plane_r >> 1);
  assign ctl.issue = issuing_r;
  assign ctl.minus = plane_r[0];
  assign ctl.first = (term_r == '0);
  assign ctl.last  = (term_r == TERM_W'(NUM_TERMS-1));
  assign ctl.wterm = ctl.last;
  assign opd.r3    = row_r[NUM_ROWS-1][term_r];
  assign opd.rk    = row_r[axis][term_r];
  assign opd.mn    = box_mn_r[term_r];
  assign opd.mx    = box_mx_r[term_r];

  afc_dot u_dot (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .opd   (opd),
    .stat  (stat)
  );

  // Sequencer, plane verdicts and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      issuing_r    <= 1'b0;
      plane_r      <= '0;
      term_r       <= '0;
      done_cnt_r   <= '0;
      visible_r    <= 1'b1;
      out_tvalid_r <= 1'b0;
      out_vis_r    <= 1'b0;
    end else begin
      // The hold state reloads the output register itself.
      if (out_tvalid_r && out_tready && state_r != S_HOLD) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire && in_func == FUNC_TEST) begin
            state_r    <= S_RUN;
            issuing_r  <= 1'b1;
            plane_r    <= '0;
            term_r     <= '0;
            done_cnt_r <= '0;
            visible_r  <= 1'b1;
          end
        end
        S_RUN: begin
          if (issuing_r) begin
            if (ctl.last) begin
              term_r <= '0;
              if (plane_r == PLANE_W'(NUM_PLANES-1)) begin
                issuing_r <= 1'b0;
              end else begin
                plane_r <= plane_r + 1'b1;
              end
            end else begin
              term_r <= term_r + 1'b1;
            end
          end
          if (stat.done) begin
            visible_r  <= visible_r & ~stat.neg;
            done_cnt_r <= done_cnt_r + 1'b1;
            if (done_cnt_r == PLANE_W'(NUM_PLANES-1)) begin
              state_r <= S_HOLD;
            end
          end
        end
        S_HOLD: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_vis_r    <= visible_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DATA_W-1){1'b0}}, out_vis_r};

  // A test beat keeps the input closed on the next cycle.
  `AFC_ASSERT_NXT(a_test_busy, clk, rst_n, in_fire && in_func == FUNC_TEST, !in_tready)
  // A result beat only appears after the hold state.
  `AFC_ASSERT_IMP(a_out_from_hold, clk, rst_n, $rose(out_tvalid_r), $past(state_r == S_HOLD))
  // Plane verdicts only arrive while a test runs.
  `AFC_ASSERT_IMP(a_done_in_run, clk, rst_n, stat.done, state_r == S_RUN)
  // Terms are only issued while a test runs.
  `AFC_ASSERT_IMP(a_issue_ahead, clk, rst_n, issuing_r, state_r == S_RUN)
  // Never more verdicts than planes.
  `AFC_ASSERT_IMP(a_done_cnt, clk, rst_n, state_r == S_RUN, done_cnt_r <= PLANE_W'(NUM_PLANES-1))

endmodule
